// File: sv/omfh_pkg.sv
// Shared types and codes for the owned mutex with FIFO hand-off.
// Depends on nothing; the queue, the core and the bench use it by scoped names.
package omfh_pkg;

   localparam int TID_BITS = 8;

   typedef enum logic [2:0] {
      KIND_LOCK    = 3'd0,
      KIND_UNLOCK  = 3'd1,
      KIND_TRYLOCK = 3'd2,
      KIND_DESTROY = 3'd3,
      KIND_INIT    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      STATUS_ACQUIRED       = 4'd0,
      STATUS_QUEUED         = 4'd1,
      STATUS_BUSY           = 4'd2,
      STATUS_RELEASED       = 4'd3,
      STATUS_HANDOFF        = 4'd4,
      STATUS_NOT_OWNER      = 4'd5,
      STATUS_DESTROY_OK     = 4'd6,
      STATUS_DESTROY_LOCKED = 4'd7,
      STATUS_QUEUE_FULL     = 4'd8,
      STATUS_INITIALIZED    = 4'd9
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [TID_BITS-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic [3:0]          status;
      logic                wake_valid;
      logic [TID_BITS-1:0] wake_thread;
      logic                is_locked;
      logic [TID_BITS-1:0] owner_thread;
   } rsp_type;

   // One queue operation per executed request.
   typedef struct packed {
      logic                push;
      logic                pop;
      logic                clear;
      logic [TID_BITS-1:0] data;
   } queue_cmd_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [TID_BITS-1:0] head_data;
   } queue_stat_type;

endpackage

// File: sv/omfh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module omfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/omfh_queue.sv
// Wait queue of thread ids: head/tail pointers and fill count around one RAM.
// Depends on omfh_pkg and omfh_ram.
module omfh_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  omfh_pkg::queue_cmd_type cmd,
   output omfh_pkg::queue_stat_type stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [omfh_pkg::TID_BITS-1:0] head_data;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      next_slot = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd.push) begin
         tail_in  = next_slot(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in  = next_slot(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Read the head entry every cycle; a pushed entry is written before any later request can use it.
   omfh_ram #(
      .WIDTH(omfh_pkg::TID_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push && !cmd.clear),
      .wr_addr (tail_ff),
      .wr_data (cmd.data),
      .rd_addr (head_ff),
      .rd_data (head_data)
   );

   always_comb begin
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
      stat.head_data = head_data;
   end

endmodule

// File: sv/owned_mutex_fifo_handoff_core.sv
// Top level of the owned mutex with a FIFO of waiting threads.
// Depends on omfh_pkg and omfh_queue (which holds the wait queue RAM).
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   omfh_pkg::req_type  (kind, thread_id)
//   rsp       out        rsp_valid/rsp_ready   omfh_pkg::rsp_type  (status .. owner_thread)
//
// Each item is accepted in ST_IDLE while the wait queue RAM reads its head entry,
// then applied in ST_EXEC against the lock flag, owner and queue; no new item is taken before that.
// ST_EXEC waits while the output register still holds an untaken item.
// An item of unknown kind is accepted and gives no result.
// Synchronous active-high reset clears the lock, owner and queue pointers.
module owned_mutex_fifo_handoff_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  omfh_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output omfh_pkg::rsp_type rsp_payload
);

   omfh_pkg::state_type state_ff, state_in;
   omfh_pkg::req_type   req_ff, req_in;
   omfh_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                lock_ff, lock_in;
   logic [omfh_pkg::TID_BITS-1:0] owner_ff, owner_in;

   omfh_pkg::queue_cmd_type  q_cmd;
   omfh_pkg::queue_stat_type q_stat;

   logic out_free;
   logic emit;
   logic [3:0] status;
   logic wake_v;
   logic [omfh_pkg::TID_BITS-1:0] wake_t;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         omfh_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = omfh_pkg::ST_EXEC;
            end
         end
         omfh_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = omfh_pkg::ST_IDLE;
            end
         end
         default: state_in = omfh_pkg::ST_IDLE;
      endcase
   end

   // Outputs and request execution
   always_comb begin
      req_ready = (state_ff == omfh_pkg::ST_IDLE) && !reset;
      req_in    = req_ff;
      lock_in   = lock_ff;
      owner_in  = owner_ff;
      q_cmd     = '{push: 1'b0, pop: 1'b0, clear: 1'b0, data: req_ff.thread_id};
      emit      = 1'b0;
      status    = omfh_pkg::STATUS_ACQUIRED;
      wake_v    = 1'b0;
      wake_t    = '0;

      if (req_ready && req_valid) begin
         req_in = req_payload;
      end

      if (state_ff == omfh_pkg::ST_EXEC && out_free) begin
         emit = 1'b1;
         case (req_ff.kind)
            omfh_pkg::KIND_LOCK: begin
               if (!lock_ff) begin
                  lock_in  = 1'b1;
                  owner_in = req_ff.thread_id;
                  status   = omfh_pkg::STATUS_ACQUIRED;
               end else if (q_stat.full) begin
                  status = omfh_pkg::STATUS_QUEUE_FULL;
               end else begin
                  q_cmd.push = 1'b1;
                  status     = omfh_pkg::STATUS_QUEUED;
               end
            end
            omfh_pkg::KIND_UNLOCK: begin
               if (owner_ff != req_ff.thread_id) begin
                  status = omfh_pkg::STATUS_NOT_OWNER;
               end else if (q_stat.empty) begin
                  lock_in = 1'b0;
                  status  = omfh_pkg::STATUS_RELEASED;
               end else begin
                  // hand the mutex to the oldest waiter
                  q_cmd.pop = 1'b1;
                  owner_in  = q_stat.head_data;
                  wake_v    = 1'b1;
                  wake_t    = q_stat.head_data;
                  status    = omfh_pkg::STATUS_HANDOFF;
               end
            end
            omfh_pkg::KIND_TRYLOCK: begin
               if (lock_ff) begin
                  status = omfh_pkg::STATUS_BUSY;
               end else begin
                  lock_in  = 1'b1;
                  owner_in = req_ff.thread_id;
                  status   = omfh_pkg::STATUS_ACQUIRED;
               end
            end
            omfh_pkg::KIND_DESTROY: begin
               status = lock_ff ? omfh_pkg::STATUS_DESTROY_LOCKED
                                : omfh_pkg::STATUS_DESTROY_OK;
            end
            omfh_pkg::KIND_INIT: begin
               lock_in     = 1'b0;
               q_cmd.clear = 1'b1;
               status      = omfh_pkg::STATUS_INITIALIZED;
            end
            default: begin
               // drop unknown kinds
               emit = 1'b0;
            end
         endcase
      end

      rsp_in = rsp_ff;
      if (emit) begin
         rsp_in.status       = status;
         rsp_in.wake_valid   = wake_v;
         rsp_in.wake_thread  = wake_t;
         rsp_in.is_locked    = lock_in;
         rsp_in.owner_thread = owner_in;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= omfh_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lock_ff      <= 1'b0;
         owner_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lock_ff      <= lock_in;
         owner_ff     <= owner_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   omfh_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .stat  (q_stat)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: sim/owned_mutex_fifo_handoff_core_tb.sv
// Self-checking bench for owned_mutex_fifo_handoff_core: scripted mutex traffic, then random
// lock/unlock/trylock/destroy/init and unknown-kind traffic checked against a mutex and wait-queue tracker.
// Depends on omfh_pkg and the core RTL only.
`timescale 1ns / 100ps

module owned_mutex_fifo_handoff_core_tb;

   localparam int CLK_PERIOD   = 10;
   localparam int WAIT_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 600;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AT_ITEM = 150;
   localparam int SCRIPT_ROWS  = 15;
   localparam logic [2:0] KIND_RESERVED = 3'd7;

   typedef struct packed {
      logic [2:0]                    kind;
      logic [omfh_pkg::TID_BITS-1:0] tid;
      logic [4:0]                    reps;
      logic                          fixed;
      omfh_pkg::rsp_type             reply;
   } script_row_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_MOSTLY
   } sink_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   omfh_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   omfh_pkg::rsp_type rsp_payload;

   owned_mutex_fifo_handoff_core #(
      .QUEUE_DEPTH(WAIT_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mutex tracker state
   logic                          mutex_held = 1'b0;
   logic [omfh_pkg::TID_BITS-1:0] mutex_owner = '0;
   logic [omfh_pkg::TID_BITS-1:0] waiters [WAIT_DEPTH];
   int                            waiter_head = 0;
   int                            waiter_tail = 0;
   int                            waiter_count = 0;

   omfh_pkg::rsp_type replies_due [$];
   script_row_type    script [SCRIPT_ROWS];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   int                burst_left = 0;
   logic              hold_armed = 1'b0;
   logic              hold_done = 1'b0;
   int                hold_left = 0;
   sink_mode_type     sink_mode = SINK_OPEN;
   int                sink_left = 0;
   int                sink_phase = 0;
   omfh_pkg::rsp_type reply_head;

   task automatic mutex_apply(input omfh_pkg::req_type rq, output bit gives,
                              output omfh_pkg::rsp_type res);
      logic [3:0]                    st;
      logic                          wv;
      logic [omfh_pkg::TID_BITS-1:0] wt;
      gives = 1'b1;
      st = omfh_pkg::STATUS_ACQUIRED;
      wv = 1'b0;
      wt = '0;
      case (rq.kind)
         omfh_pkg::KIND_LOCK: begin
            if (!mutex_held) begin
               mutex_held = 1'b1;
               mutex_owner = rq.thread_id;
               st = omfh_pkg::STATUS_ACQUIRED;
            end else if (waiter_count >= WAIT_DEPTH) begin
               st = omfh_pkg::STATUS_QUEUE_FULL;
            end else begin
               waiters[waiter_tail] = rq.thread_id;
               waiter_tail = (waiter_tail + 1) % WAIT_DEPTH;
               waiter_count++;
               st = omfh_pkg::STATUS_QUEUED;
            end
         end
         omfh_pkg::KIND_UNLOCK: begin
            if (mutex_owner != rq.thread_id) begin
               st = omfh_pkg::STATUS_NOT_OWNER;
            end else if (waiter_count == 0) begin
               mutex_held = 1'b0;
               st = omfh_pkg::STATUS_RELEASED;
            end else begin
               wt = waiters[waiter_head];
               waiter_head = (waiter_head + 1) % WAIT_DEPTH;
               waiter_count--;
               mutex_owner = wt;
               wv = 1'b1;
               st = omfh_pkg::STATUS_HANDOFF;
            end
         end
         omfh_pkg::KIND_TRYLOCK: begin
            if (mutex_held) begin
               st = omfh_pkg::STATUS_BUSY;
            end else begin
               mutex_held = 1'b1;
               mutex_owner = rq.thread_id;
               st = omfh_pkg::STATUS_ACQUIRED;
            end
         end
         omfh_pkg::KIND_DESTROY: begin
            st = mutex_held ? omfh_pkg::STATUS_DESTROY_LOCKED : omfh_pkg::STATUS_DESTROY_OK;
         end
         omfh_pkg::KIND_INIT: begin
            mutex_held = 1'b0;
            waiter_head = 0;
            waiter_tail = 0;
            waiter_count = 0;
            st = omfh_pkg::STATUS_INITIALIZED;
         end
         default: begin
            gives = 1'b0;
         end
      endcase
      res.status = st;
      res.wake_valid = wv;
      res.wake_thread = wt;
      res.is_locked = mutex_held;
      res.owner_thread = mutex_owner;
   endtask

   function automatic script_row_type fixed_row(logic [2:0] k,
                                                logic [omfh_pkg::TID_BITS-1:0] tid,
                                                omfh_pkg::status_type st, logic wv,
                                                logic [omfh_pkg::TID_BITS-1:0] wt, logic lk,
                                                logic [omfh_pkg::TID_BITS-1:0] ow);
      script_row_type r;
      r.kind = k;
      r.tid = tid;
      r.reps = 5'd1;
      r.fixed = 1'b1;
      r.reply.status = st;
      r.reply.wake_valid = wv;
      r.reply.wake_thread = wt;
      r.reply.is_locked = lk;
      r.reply.owner_thread = ow;
      return r;
   endfunction

   function automatic script_row_type free_row(logic [2:0] k,
                                               logic [omfh_pkg::TID_BITS-1:0] tid,
                                               logic [4:0] reps);
      script_row_type r;
      r = '0;
      r.kind = k;
      r.tid = tid;
      r.reps = reps;
      return r;
   endfunction

   // Hold valid and payload until the item is taken.
   task automatic offer_item(input omfh_pkg::req_type item);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Drop valid for a random gap once the current burst is used up.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 80);
         else burst_left = $urandom_range(0, 12);
      end
   endtask

   initial begin
      omfh_pkg::req_type item;
      omfh_pkg::rsp_type predicted;
      bit                gives;
      int                row;
      int                rep;
      int                counted;
      int                roll;
      int                mode_left;
      bit                drain_mode;

      // Fixed replies follow straight from the reset state and the queue contents.
      script[0]  = fixed_row(omfh_pkg::KIND_DESTROY, 8'h00, omfh_pkg::STATUS_DESTROY_OK,
                             1'b0, 8'h00, 1'b0, 8'h00);
      script[1]  = fixed_row(omfh_pkg::KIND_UNLOCK, 8'h00, omfh_pkg::STATUS_RELEASED,
                             1'b0, 8'h00, 1'b0, 8'h00);
      script[2]  = fixed_row(omfh_pkg::KIND_UNLOCK, 8'hFF, omfh_pkg::STATUS_NOT_OWNER,
                             1'b0, 8'h00, 1'b0, 8'h00);
      script[3]  = fixed_row(omfh_pkg::KIND_TRYLOCK, 8'hFF, omfh_pkg::STATUS_ACQUIRED,
                             1'b0, 8'h00, 1'b1, 8'hFF);
      script[4]  = fixed_row(omfh_pkg::KIND_TRYLOCK, 8'h00, omfh_pkg::STATUS_BUSY,
                             1'b0, 8'h00, 1'b1, 8'hFF);
      script[5]  = fixed_row(omfh_pkg::KIND_DESTROY, 8'h5A, omfh_pkg::STATUS_DESTROY_LOCKED,
                             1'b0, 8'h00, 1'b1, 8'hFF);
      // Holder queues behind itself, then fill the rest of the queue.
      script[6]  = free_row(omfh_pkg::KIND_LOCK, 8'hFF, 5'd1);
      script[7]  = free_row(omfh_pkg::KIND_LOCK, 8'h01, 5'd15);
      script[8]  = fixed_row(omfh_pkg::KIND_LOCK, 8'hA5, omfh_pkg::STATUS_QUEUE_FULL,
                             1'b0, 8'h00, 1'b1, 8'hFF);
      script[9]  = fixed_row(omfh_pkg::KIND_UNLOCK, 8'hFF, omfh_pkg::STATUS_HANDOFF,
                             1'b1, 8'hFF, 1'b1, 8'hFF);
      script[10] = free_row(omfh_pkg::KIND_UNLOCK, 8'hFF, 5'd1);
      script[11] = free_row(KIND_RESERVED, 8'h80, 5'd1);
      script[12] = fixed_row(omfh_pkg::KIND_INIT, 8'h3C, omfh_pkg::STATUS_INITIALIZED,
                             1'b0, 8'h00, 1'b0, 8'h01);
      script[13] = fixed_row(omfh_pkg::KIND_UNLOCK, 8'h01, omfh_pkg::STATUS_RELEASED,
                             1'b0, 8'h00, 1'b0, 8'h01);
      script[14] = fixed_row(omfh_pkg::KIND_LOCK, 8'h80, omfh_pkg::STATUS_ACQUIRED,
                             1'b0, 8'h00, 1'b1, 8'h80);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < SCRIPT_ROWS; row++) begin
         for (rep = 0; rep < script[row].reps; rep++) begin
            item.kind = script[row].kind;
            item.thread_id = script[row].tid + rep[omfh_pkg::TID_BITS-1:0];
            offer_item(item);
            mutex_apply(item, gives, predicted);
            if (gives) replies_due.push_back(script[row].fixed ? script[row].reply : predicted);
            pace_sender();
         end
      end

      // Alternate lock-heavy and unlock-heavy stretches so the queue fills and drains.
      counted = 0;
      mode_left = 0;
      drain_mode = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            drain_mode = ~drain_mode;
            mode_left = $urandom_range(20, 60);
         end else begin
            mode_left--;
         end
         roll = $urandom_range(0, 99);
         if (roll < (drain_mode ? 15 : 60)) item.kind = omfh_pkg::KIND_LOCK;
         else if (roll < (drain_mode ? 65 : 72)) item.kind = omfh_pkg::KIND_UNLOCK;
         else if (roll < (drain_mode ? 78 : 82)) item.kind = omfh_pkg::KIND_TRYLOCK;
         else if (roll < (drain_mode ? 90 : 92)) item.kind = omfh_pkg::KIND_DESTROY;
         else if (roll < (drain_mode ? 95 : 96)) item.kind = omfh_pkg::KIND_INIT;
         else item.kind = 3'($urandom_range(omfh_pkg::KIND_INIT + 1, KIND_RESERVED));

         if (item.kind == omfh_pkg::KIND_UNLOCK && $urandom_range(0, 3) != 0)
            item.thread_id = mutex_owner;
         else if ($urandom_range(0, 1) == 0)
            item.thread_id = omfh_pkg::TID_BITS'($urandom_range(0, 7));
         else
            item.thread_id = omfh_pkg::TID_BITS'($urandom_range(0, 255));

         offer_item(item);
         mutex_apply(item, gives, predicted);
         if (gives) begin
            replies_due.push_back(predicted);
            counted++;
         end
         // Stall the response side while the sender keeps pushing.
         if (counted == HOLD_AT_ITEM && !hold_armed) begin
            hold_armed <= 1'b1;
            burst_left = 120;
         end
         pace_sender();
      end
      req_valid <= 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Response side: rotating stall patterns plus one long hold-off.
   always @(posedge clock) begin
      sink_phase <= sink_phase + 1;
      if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode <= sink_mode_type'(2'($urandom_range(0, 3)));
            sink_left <= $urandom_range(10, 60);
         end else begin
            sink_left <= sink_left - 1;
         end
         case (sink_mode)
            SINK_OPEN:   rsp_ready <= 1'b1;
            SINK_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: rsp_ready <= (sink_phase % 4 == 0);
            default:     rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected reply: status %0d wake %0b/%02h locked %0b owner %02h",
                        rsp_payload.status, rsp_payload.wake_valid, rsp_payload.wake_thread,
                        rsp_payload.is_locked, rsp_payload.owner_thread);
            mismatch_count++;
         end else begin
            reply_head = replies_due.pop_front();
            if (rsp_payload.status !== reply_head.status ||
                rsp_payload.wake_valid !== reply_head.wake_valid ||
                rsp_payload.wake_thread !== reply_head.wake_thread ||
                rsp_payload.is_locked !== reply_head.is_locked ||
                rsp_payload.owner_thread !== reply_head.owner_thread) begin
               if (mismatch_count < 10) begin
                  $display("reply mismatch at %0t", $realtime);
                  $display("  want status %0d wake %0b/%02h locked %0b owner %02h",
                           reply_head.status, reply_head.wake_valid, reply_head.wake_thread,
                           reply_head.is_locked, reply_head.owner_thread);
                  $display("  got  status %0d wake %0b/%02h locked %0b owner %02h",
                           rsp_payload.status, rsp_payload.wake_valid,
                           rsp_payload.wake_thread, rsp_payload.is_locked,
                           rsp_payload.owner_thread);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: files.f
sv/omfh_pkg.sv
sv/omfh_ram.sv
sv/omfh_queue.sv
sv/owned_mutex_fifo_handoff_core.sv
sim/owned_mutex_fifo_handoff_core_tb.sv
